[hw/rtl/scwp_pkg.sv]
package scwp_pkg;

	localparam int MAX_RECTS = 256;
	localparam int EVT_CAP   = 2 * MAX_RECTS;
	localparam int CNT_W     = $clog2(EVT_CAP + 1);
	localparam int POS_W     = 16;
	localparam int SCORE_W   = 29;
	localparam int TOT_W     = SCORE_W + $clog2(MAX_RECTS + 1) + 1;
	localparam int DIM_W     = 14;
	localparam int OFF_W     = 13;
	localparam logic [OFF_W-1:0] OFFSET_MAX = 13'd8191;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 14'd640;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 14'd480;
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t                   op;
		logic signed [POS_W-1:0]    new_pos;
		logic signed [SCORE_W-1:0]  new_score;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INS2,
		ST_SCAN
	} state_t;

endpackage

[hw/rtl/scwp_cell.sv]
module scwp_cell import scwp_pkg::*; (
	input  logic                       clk,
	input  cell_ctl_t                  ctl,
	input  logic                       valid,
	input  logic                       left_valid,
	input  logic                       left_gt,
	input  logic signed [POS_W-1:0]    left_pos,
	input  logic signed [SCORE_W-1:0]  left_score,
	input  logic signed [POS_W-1:0]    right_pos,
	input  logic signed [SCORE_W-1:0]  right_score,
	output logic signed [POS_W-1:0]    pos,
	output logic signed [SCORE_W-1:0]  score,
	output logic                       gt
);

	logic signed [POS_W-1:0]   pos_q;
	logic signed [SCORE_W-1:0] score_q;

	// flag an entry that sorts after the new event
	assign gt    = valid && (pos_q > ctl.new_pos);
	assign pos   = pos_q;
	assign score = score_q;

	// insert: shift right past the gap, new event in it; shift: move left
	always_ff @(posedge clk) begin
		case (ctl.op)
			CELL_INSERT: begin
				if (left_gt) begin
					pos_q   <= left_pos;
					score_q <= left_score;
				end else if (gt || (!valid && left_valid)) begin
					pos_q   <= ctl.new_pos;
					score_q <= ctl.new_score;
				end
			end
			CELL_SHIFT: begin
				pos_q   <= right_pos;
				score_q <= right_score;
			end
			default: begin
			end
		endcase
	end

endmodule

[hw/rtl/square_crop_window_picker_top.sv]
// Square crop window picker.
// Input stream (s_*): one beat per content rectangle. tdata carries the
// rectangle geometry, tuser the has_rect and is_face flags, tlast closes the
// set. A beat with has_rect low only closes the set when tlast is high.
// Output stream (m_*): one result beat per set, after the beat with tlast.
// APB port: image_width at 0x0, image_height at 0x4; write only while idle.
// A rectangle beat is inserted into the sorted cell chain as two events,
// one per cycle, and the input is not ready during the second insertion;
// a non-final beat without a stored rectangle leaves the input ready.
// After the last beat's insertions the chain is shifted out through
// cell 0, one event per cycle, and the result is loaded into the output
// register once the chain is empty.
// Reset empties the chain, clears the overflow flag and restores the image
// registers to 640 x 480. When the receiver stalls the result holds in the
// output register; further beats are still accepted, and a
// following set waits at the end of its scan until the register is free.
module square_crop_window_picker_top import scwp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// rect_x[12:0], rect_y[25:13], rect_width[39:26], rect_height[53:40]
	input  logic [55:0] s_tdata,
	// has_rect[0], is_face[1]
	input  logic [1:0]  s_tuser,
	input  logic        s_tlast,
	input  logic        s_tvalid,
	output logic        s_tready,
	// crop_x[13:0], crop_y[27:14], crop_side[41:28]
	output logic [47:0] m_tdata,
	// centered[0], overflowed[1]
	output logic [1:0]  m_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [DIM_W-1:0] width_q, height_q;
	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             overflow_q, overflow_d;
	logic             found_q, found_d;
	logic signed [TOT_W-1:0]   total_q, total_d, best_q, best_d;
	logic [POS_W-2:0]          bpos_q, bpos_d;
	logic signed [POS_W-1:0]   leave_q;
	logic signed [SCORE_W-1:0] nscore_q;
	logic                      last_q;
	logic                      m_tvalid_q;
	logic [47:0]               m_tdata_q;
	logic [1:0]                m_tuser_q;
	logic                      load_out;
	cell_ctl_t                 ctl;

	// APB register file
	assign pready = 1'b1;
	assign prdata = {18'd0, (paddr[2] == REG_HEIGHT) ? height_q : width_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_WIDTH) width_q <= pwdata[DIM_W-1:0];
			else height_q <= pwdata[DIM_W-1:0];
		end
	end

	// unpack input beat
	logic [12:0]      rect_x, rect_y;
	logic [DIM_W-1:0] rect_w, rect_h;
	logic             has_rect, is_face, axis_x;
	logic [DIM_W-1:0] side;
	logic [27:0]      area;
	logic signed [SCORE_W-1:0] score_in;
	logic signed [POS_W-1:0]   enter_pos, leave_pos;
	logic             fits;

	assign rect_x   = s_tdata[12:0];
	assign rect_y   = s_tdata[25:13];
	assign rect_w   = s_tdata[39:26];
	assign rect_h   = s_tdata[53:40];
	assign has_rect = s_tuser[0];
	assign is_face  = s_tuser[1];
	assign axis_x   = width_q > height_q;
	assign side     = (width_q < height_q) ? width_q : height_q;
	assign area     = 28'(rect_w) * 28'(rect_h);
	assign score_in = (is_face && area > 28'd1) ? $signed({1'b0, area}) : SCORE_W'(1);
	assign enter_pos = axis_x
		? $signed(POS_W'(rect_x) + POS_W'(rect_w) - POS_W'(side))
		: $signed(POS_W'(rect_y) + POS_W'(rect_h) - POS_W'(side));
	assign leave_pos = $signed(POS_W'(axis_x ? rect_x : rect_y));
	assign fits      = count_q <= CNT_W'(EVT_CAP - 2);

	// cell chain
	logic signed [POS_W-1:0]   pos_w   [EVT_CAP];
	logic signed [SCORE_W-1:0] score_w [EVT_CAP];
	logic                      gt_w    [EVT_CAP];
	logic                      valid_w [EVT_CAP];

	genvar gi;
	generate
		for (gi = 0; gi < EVT_CAP; gi++) begin : g_cell
			assign valid_w[gi] = count_q > CNT_W'(gi);
			scwp_cell u_cell (
				.clk         (clk),
				.ctl         (ctl),
				.valid       (valid_w[gi]),
				.left_valid  ((gi == 0) ? 1'b1 : valid_w[(gi == 0) ? 0 : gi-1]),
				.left_gt     ((gi == 0) ? 1'b0 : gt_w[(gi == 0) ? 0 : gi-1]),
				.left_pos    (pos_w[(gi == 0) ? 0 : gi-1]),
				.left_score  (score_w[(gi == 0) ? 0 : gi-1]),
				.right_pos   (pos_w[(gi == EVT_CAP-1) ? gi : gi+1]),
				.right_score (score_w[(gi == EVT_CAP-1) ? gi : gi+1]),
				.pos         (pos_w[gi]),
				.score       (score_w[gi]),
				.gt          (gt_w[gi])
			);
		end
	endgenerate

	// scan step on the head cell
	logic                    cand;
	logic signed [TOT_W-1:0] run_total;
	logic [DIM_W-1:0]        dim;
	logic [OFF_W-1:0]        off;

	assign cand = !pos_w[0][POS_W-1] || (count_q >= CNT_W'(2) && !pos_w[1][POS_W-1]);
	assign run_total = total_q + TOT_W'(score_w[0]);
	assign dim = axis_x ? width_q : height_q;

	always_comb begin
		if (found_q) off = (bpos_q > (POS_W-1)'(OFFSET_MAX)) ? OFFSET_MAX : bpos_q[OFF_W-1:0];
		else off = OFF_W'((dim >> 1) - (side >> 1));
	end

	// sequencer: next state, chain control
	always_comb begin
		state_d    = state_q;
		count_d    = count_q;
		overflow_d = overflow_q;
		found_d    = found_q;
		total_d    = total_q;
		best_d     = best_q;
		bpos_d     = bpos_q;
		load_out   = 1'b0;
		s_tready   = 1'b0;
		ctl.op        = CELL_HOLD;
		ctl.new_pos   = enter_pos;
		ctl.new_score = score_in;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (has_rect && fits) begin
						ctl.op  = CELL_INSERT;
						count_d = count_q + 1'b1;
						state_d = ST_INS2;
					end else begin
						if (has_rect) overflow_d = 1'b1;
						if (s_tlast) state_d = ST_SCAN;
					end
				end
			end
			ST_INS2: begin
				ctl.op        = CELL_INSERT;
				ctl.new_pos   = leave_q;
				ctl.new_score = nscore_q;
				count_d       = count_q + 1'b1;
				state_d       = last_q ? ST_SCAN : ST_IDLE;
			end
			ST_SCAN: begin
				if (count_q != '0) begin
					ctl.op  = CELL_SHIFT;
					count_d = count_q - 1'b1;
					total_d = run_total;
					if (cand && (!found_q || run_total > best_q)) begin
						found_d = 1'b1;
						best_d  = run_total;
						bpos_d  = pos_w[0][POS_W-1] ? '0 : pos_w[0][POS_W-2:0];
					end
				end else if (!m_tvalid_q || m_tready) begin
					load_out   = 1'b1;
					overflow_d = 1'b0;
					found_d    = 1'b0;
					total_d    = '0;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			overflow_q <= 1'b0;
			found_q    <= 1'b0;
			total_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			overflow_q <= overflow_d;
			found_q    <= found_d;
			total_q    <= total_d;
			if (load_out) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// hold the exit event, the best candidate and the result beat
	always_ff @(posedge clk) begin
		best_q <= best_d;
		bpos_q <= bpos_d;
		if (state_q == ST_IDLE && s_tvalid) begin
			leave_q  <= leave_pos;
			nscore_q <= -score_in;
			last_q   <= s_tlast;
		end
		if (load_out) begin
			m_tdata_q <= {6'd0, side,
				axis_x ? 14'd0 : {1'b0, off},
				axis_x ? {1'b0, off} : 14'd0};
			m_tuser_q <= {overflow_q, !found_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

[hw/rtl/scwp_checker.sv]
module scwp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tlast,
	input logic [47:0] m_tdata,
	input logic        m_tvalid,
	input logic        m_tready
);

	// hold a stalled result beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat dropped or changed under stall");

	// go busy after a closing beat
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input accepted while closing a set");

	// keep the crop on one axis only
	a_one_axis: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[13:0] == 14'd0 || m_tdata[27:14] == 14'd0))
		else $error("crop offset on both axes");

	// keep the offset non-negative
	a_offset_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !m_tdata[13] && !m_tdata[27])
		else $error("negative crop offset");

endmodule

bind square_crop_window_picker_top scwp_checker u_scwp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);
